[rtl/core/extended_binary_gcd_core_macros.svh]
// Assertion macros for the extended binary gcd core
`ifndef EXTENDED_BINARY_GCD_CORE_MACROS_SVH
`define EXTENDED_BINARY_GCD_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define EBG_ASSERT_IMPL(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define EBG_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define EBG_ASSERT_IMPL(lbl, prop, msg)
`define EBG_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

[rtl/core/ebgcd_pkg.sv]
package ebgcd_pkg;
    localparam int OPERAND_BITS = 31;
    localparam int WORK_BITS = OPERAND_BITS + 2;
    localparam int K_BITS = $clog2(OPERAND_BITS + 1);

    typedef struct packed {
        logic [OPERAND_BITS-1:0] first_operand;
        logic [OPERAND_BITS-1:0] second_operand;
    } operands_t;

    typedef struct packed {
        logic [OPERAND_BITS-1:0] coef_large;
        logic [OPERAND_BITS-1:0] coef_small;
        logic [OPERAND_BITS-1:0] gcd_value;
        logic                    operands_swapped;
        logic                    input_error;
    } result_t;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_STRIP = 6'b000010,
        ST_INNER = 6'b000100,
        ST_FIX   = 6'b001000,
        ST_FINAL = 6'b010000,
        ST_SHIFT = 6'b100000
    } state_t;
endpackage

[rtl/core/extended_binary_gcd_core.sv]
// Extended binary gcd core, one shared add/compare/halve step per cycle.
// Run time is data dependent, set by the iteration loops through the work
// registers; a zero operand is flagged in the cycle after start, from idle.
// Throughput: one command at a time; busy stays high until the done beat.
// Reset (rst_n low, async) returns to idle with no result pending.
`include "extended_binary_gcd_core_macros.svh"
module extended_binary_gcd_core
    import ebgcd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  operands_t operands,
    output logic      done,
    output result_t   result
);
    localparam int N = OPERAND_BITS;
    localparam int W = WORK_BITS;

    state_t state_reg, state_next;
    logic [W-1:0] u_reg, u_next, v_reg, v_next;
    logic [W-1:0] a_reg, a_next, b_reg, b_next, g_reg, g_next;
    logic [W-1:0] ta_reg, ta_next, tb_reg, tb_next, tg_reg, tg_next;
    logic [K_BITS-1:0] k_reg, k_next;
    logic swap_reg, swap_next;
    logic done_reg, done_next;
    result_t result_reg, result_next;
    logic zero_in;
    logic err_beat;

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    assign zero_in  = (operands.first_operand == '0) || (operands.second_operand == '0);
    assign err_beat = done && result.input_error;

    always_comb
    begin
        logic [W-1:0] a1, b1, g1, fu, fv;
        logic sw;
        state_next  = state_reg;
        u_next = u_reg; v_next = v_reg;
        a_next = a_reg; b_next = b_reg; g_next = g_reg;
        ta_next = ta_reg; tb_next = tb_reg; tg_next = tg_reg;
        k_next = k_reg; swap_next = swap_reg;
        done_next = 1'b0;
        result_next = result_reg;
        a1 = a_reg; b1 = b_reg; g1 = g_reg; sw = 1'b0;
        fu = {2'b00, operands.first_operand};
        fv = {2'b00, operands.second_operand};
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (fu == '0 || fv == '0)
                    begin
                        result_next = '0;
                        result_next.input_error = 1'b1;
                        done_next = 1'b1;
                    end
                    else
                    begin
                        swap_next = (fu < fv);
                        u_next = (fu < fv) ? fv : fu;
                        v_next = (fu < fv) ? fu : fv;
                        k_next = '0;
                        state_next = ST_STRIP;
                    end
                end
            end
            ST_STRIP:
            begin
                if (!u_reg[0] && !v_reg[0])
                begin
                    u_next = u_reg >> 1;
                    v_next = v_reg >> 1;
                    k_next = k_reg + K_BITS'(1);
                end
                else
                begin
                    a_next = W'(1); b_next = '0; g_next = u_reg;
                    ta_next = v_reg; tb_next = u_reg - W'(1); tg_next = v_reg;
                    state_next = ST_INNER;
                end
            end
            ST_INNER:
            begin
                if (!g_reg[0])
                begin
                    if (a_reg[0] || b_reg[0])
                    begin
                        a1 = a_reg + v_reg;
                        b1 = b_reg + u_reg;
                    end
                    a1 = a1 >> 1; b1 = b1 >> 1; g1 = g_reg >> 1;
                end
                sw = !tg_reg[0] || (g1 < tg_reg);
                a_next  = sw ? ta_reg : a1;
                b_next  = sw ? tb_reg : b1;
                g_next  = sw ? tg_reg : g1;
                ta_next = sw ? a1 : ta_reg;
                tb_next = sw ? b1 : tb_reg;
                tg_next = sw ? g1 : tg_reg;
                if (g_next[0])
                    state_next = ST_FIX;
            end
            ST_FIX:
            begin
                if (a_reg < ta_reg || b_reg < tb_reg)
                begin
                    a_next = a_reg + v_reg;
                    b_next = b_reg + u_reg;
                end
                else
                begin
                    a_next = a_reg - ta_reg;
                    b_next = b_reg - tb_reg;
                    g_next = g_reg - tg_reg;
                    state_next = (tg_reg != '0) ? ST_INNER : ST_FINAL;
                end
            end
            ST_FINAL:
            begin
                if (a_reg >= v_reg && b_reg >= u_reg)
                begin
                    a_next = a_reg - v_reg;
                    b_next = b_reg - u_reg;
                end
                else
                    state_next = ST_SHIFT;
            end
            ST_SHIFT:
            begin
                // restore the shared factors of two, one per cycle
                if (k_reg != '0)
                begin
                    g_next = g_reg << 1;
                    k_next = k_reg - K_BITS'(1);
                end
                else
                begin
                    result_next.coef_large = a_reg[N-1:0];
                    result_next.coef_small = b_reg[N-1:0];
                    result_next.gcd_value = g_reg[N-1:0];
                    result_next.operands_swapped = swap_reg;
                    result_next.input_error = 1'b0;
                    done_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        u_reg <= u_next; v_reg <= v_next;
        a_reg <= a_next; b_reg <= b_next; g_reg <= g_next;
        ta_reg <= ta_next; tb_reg <= tb_next; tg_reg <= tg_next;
        k_reg <= k_next; swap_reg <= swap_next;
        result_reg <= result_next;
    end

    `EBG_ASSERT_IMPL(a_done_idle, done |-> !busy, "done beat while busy")
    `EBG_ASSERT_NEXT(a_err_fast, start && !busy && zero_in, err_beat, "zero operand not flagged")
    `EBG_ASSERT_NEXT(a_start_busy, start && !busy && !zero_in, busy, "command did not set busy")
    `EBG_ASSERT_IMPL(a_err_zero, err_beat |-> (result == result_t'(1)), "error beat carries data")
    `EBG_ASSERT_IMPL(a_gcd_nz, (done && !result.input_error) |-> (result.gcd_value != '0), "zero gcd")
endmodule

[tb/extended_binary_gcd_core_test.sv]
`timescale 1ns / 1ps

module extended_binary_gcd_core_test;
    import ebgcd_pkg::*;

    localparam longint CYCLE_LIMIT = 2000000;

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    operands_t operands;
    logic      done;
    result_t   result;

    result_t pending_gcd_q[$];
    int      mismatch_count;
    longint  cycle_count;

    extended_binary_gcd_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .operands (operands),
        .done     (done),
        .result   (result)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("extended_binary_gcd_core_test: FAIL");
            $finish;
        end
    end

    // Work out the expected result of one operand pair
    function automatic result_t compute_gcd(input operands_t ops);
        logic [63:0] mask;
        logic [63:0] u;
        logic [63:0] v;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] g;
        logic [63:0] ta;
        logic [63:0] tb;
        logic [63:0] tg;
        logic [63:0] t;
        int          k;
        result_t     r;
        mask = (64'd1 << OPERAND_BITS) - 1;
        u = 64'(ops.first_operand);
        v = 64'(ops.second_operand);
        r = '0;
        k = 0;
        if (u == 0 || v == 0)
        begin
            r.input_error = 1'b1;
            return r;
        end
        if (u < v)
        begin
            t = u;
            u = v;
            v = t;
            r.operands_swapped = 1'b1;
        end
        while (!u[0] && !v[0])
        begin
            u = u >> 1;
            v = v >> 1;
            k++;
        end
        a = 1;
        b = 0;
        g = u;
        ta = v;
        tb = u - 1;
        tg = v;
        do
        begin
            do
            begin
                if (!g[0])
                begin
                    if (a[0] || b[0])
                    begin
                        a = a + v;
                        b = b + u;
                    end
                    a = a >> 1;
                    b = b >> 1;
                    g = g >> 1;
                end
                if (!tg[0] || g < tg)
                begin
                    t = a; a = ta; ta = t;
                    t = b; b = tb; tb = t;
                    t = g; g = tg; tg = t;
                end
            end while (!g[0]);
            while (a < ta || b < tb)
            begin
                a = a + v;
                b = b + u;
            end
            a = a - ta;
            b = b - tb;
            g = g - tg;
        end while (tg > 0);
        while (a >= v && b >= u)
        begin
            a = a - v;
            b = b - u;
        end
        r.coef_large = OPERAND_BITS'(a & mask);
        r.coef_small = OPERAND_BITS'(b & mask);
        r.gcd_value  = OPERAND_BITS'((g << k) & mask);
        return r;
    endfunction

    // Check each done beat against the oldest expectation
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && done)
        begin
            if (pending_gcd_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result %h", result);
            end
            else
            begin
                want = pending_gcd_q.pop_front();
                if (want !== result)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected a=%0d b=%0d g=%0d sw=%0d err=%0d, got a=%0d b=%0d g=%0d sw=%0d err=%0d",
                            want.coef_large, want.coef_small, want.gcd_value,
                            want.operands_swapped, want.input_error,
                            result.coef_large, result.coef_small, result.gcd_value,
                            result.operands_swapped, result.input_error);
                end
            end
        end
    end

    task automatic send_pair(input logic [OPERAND_BITS-1:0] x, input logic [OPERAND_BITS-1:0] y);
        operands_t ops;
        int        gap;
        ops.first_operand  = x;
        ops.second_operand = y;
        gap = $urandom_range(0, 10);
        // step past the previous accepting edge before looking at busy
        @(posedge clk);
        repeat (gap) @(posedge clk);
        while (busy) @(posedge clk);
        start    <= 1'b1;
        operands <= ops;
        pending_gcd_q.push_back(compute_gcd(ops));
        @(posedge clk);
        start <= 1'b0;
    endtask

    function automatic logic [OPERAND_BITS-1:0] rand_operand();
        logic [OPERAND_BITS-1:0] x;
        int                      width;
        width = $urandom_range(1, OPERAND_BITS);
        x = OPERAND_BITS'({$urandom, $urandom}) >> (OPERAND_BITS - width);
        // give shared factors of two a fair chance
        if ($urandom_range(0, 3) == 0)
            x = x << $urandom_range(0, 8);
        return x;
    endfunction

    task automatic wait_drained();
        while (pending_gcd_q.size() != 0) @(posedge clk);
    endtask

    task automatic test_directed();
        logic [OPERAND_BITS-1:0] top;
        logic [OPERAND_BITS-1:0] one;
        logic [OPERAND_BITS-1:0] alt;
        top = '1;
        one = OPERAND_BITS'(1);
        alt = OPERAND_BITS'(32'h2AAAAAAA);
        send_pair('0, '0);
        send_pair('0, OPERAND_BITS'(5));
        send_pair(OPERAND_BITS'(7), '0);
        send_pair(one, one);
        send_pair(top, top);
        send_pair(top, one);
        send_pair(one, top);
        send_pair(top, top - one);
        send_pair(OPERAND_BITS'(12), OPERAND_BITS'(18));
        send_pair(OPERAND_BITS'(18), OPERAND_BITS'(12));
        send_pair(OPERAND_BITS'(48), OPERAND_BITS'(48));
        send_pair(one << 30, one << 29);
        send_pair(one << 30, OPERAND_BITS'(3));
        send_pair(top, '0);
        send_pair('0, top);
        send_pair(OPERAND_BITS'(13), OPERAND_BITS'(17));
        send_pair(OPERAND_BITS'(2), one);
        send_pair(OPERAND_BITS'(1024), OPERAND_BITS'(96));
        send_pair(alt, top - alt);
        send_pair(one << 30, one << 30);
    endtask

    task automatic test_pause_drain();
        send_pair(rand_operand(), rand_operand());
        wait_drained();
        send_pair(rand_operand(), rand_operand());
    endtask

    task automatic test_random();
        logic [OPERAND_BITS-1:0] x;
        logic [OPERAND_BITS-1:0] y;
        for (int i = 0; i < 930; i++)
        begin
            x = rand_operand();
            y = rand_operand();
            if ($urandom_range(0, 40) == 0)
                x = '0;
            if ($urandom_range(0, 40) == 0)
                y = '0;
            if ($urandom_range(0, 30) == 0)
                y = x;
            send_pair(x, y);
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        start          = 1'b0;
        operands       = '0;
        mismatch_count = 0;
        cycle_count    = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_pause_drain();
        test_random();
        wait_drained();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && pending_gcd_q.size() == 0)
            $display("extended_binary_gcd_core_test: PASS");
        else
            $display("extended_binary_gcd_core_test: FAIL");
        $finish;
    end
endmodule

[files.f]
+incdir+rtl/core
rtl/core/ebgcd_pkg.sv
rtl/core/extended_binary_gcd_core.sv
tb/extended_binary_gcd_core_test.sv
